/* rtl/lct_pkg.sv */
// Shared types and constants for the link contact generator.
`timescale 1ns / 1ps
`default_nettype none
package lct_pkg;

    localparam int MAG_W  = 33;          // |second - first|
    localparam int SUM_W  = 66;          // sum of three squares
    localparam int RAD_W  = 98;          // sum scaled by 2^32
    localparam int ROOT_W = 49;          // length in units of 2^-16
    localparam int SREM_W = 52;          // root remainder after pair shift
    localparam int SQ_STAGES = 49;       // one root bit per cell
    localparam int Q_W    = 31;          // quotient bits, at most 2^30
    localparam int DREM_W = 50;          // divider remainder after shift
    localparam int NRM_W  = 32;
    localparam int PEN_W  = 32;
    localparam int REST_W = 31;
    localparam int RST_W  = 17;

    typedef enum logic [1:0] {
        CMD_PAIR_CABLE = 2'd0,
        CMD_PAIR_ROD   = 2'd1,
        CMD_ANCH_CABLE = 2'd2,
        CMD_ANCH_ROD   = 2'd3
    } t_cmd;

    // Sideband that rides along the square-root chain.
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  rod;
        logic [REST_W-1:0]     rest;
        logic [RST_W-1:0]      rst;
    } t_side;

    // Sideband that rides along the divider chain.
    typedef struct packed {
        logic [ROOT_W-1:0] den;
        logic              emit;
        logic              flip;
        logic [PEN_W-1:0]  pen;
        logic [RST_W-1:0]  rst;
        logic [2:0]        neg;
    } t_post;

endpackage
`default_nettype wire

/* rtl/lct_if.sv */
// Handshake interfaces for link beats in and contact beats out.
`timescale 1ns / 1ps
`default_nettype none
interface lct_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [30:0] rest_length;
    logic [16:0] restitution;

    modport source (output valid, cmd, first_x, first_y, first_z, second_x, second_y,
                    second_z, rest_length, restitution, input ready);
    modport sink (input valid, cmd, first_x, first_y, first_z, second_x, second_y,
                  second_z, rest_length, restitution, output ready);
endinterface

interface lct_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic [31:0] penetration;
    logic [16:0] restitution_out;

    modport source (output valid, normal_x, normal_y, normal_z, penetration,
                    restitution_out, input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, penetration,
                  restitution_out, output ready);
endinterface
`default_nettype wire

/* rtl/link_contact_generator.sv */
// Top level of the link contact generator: cable and rod contact pipeline.
//
// The block takes one link beat on i_link and gives at most one contact beat on
// o_contact. A link beat carries the kind, the two end points and the length limit;
// a contact beat carries the unit normal in Q1.30, the penetration depth and the
// restitution. Links that produce no contact (a slack cable, a rod at exactly its
// length) simply vanish from the stream; the order of contacts is kept.
// The datapath is a row of identical cells: three front stages form the squared
// length, 49 square-root cells each settle one bit of the length, one stage forms
// penetration and the emit decision, and 31 divider cells per axis settle one bit of
// each normal component. Throughput is one link per cycle while the output is not
// stalled; every stage is a registered cell, so nothing iterates in place.
// The whole pipeline advances when the output register is empty or being taken, so
// i_link.ready drops only while a contact sits at the output and the receiver holds
// o_contact.ready low; the pipeline then freezes with no beat lost.
// Synchronous reset clears all stage valid bits and the output valid; data registers
// are not reset.
`timescale 1ns / 1ps
`default_nettype none
module link_contact_generator (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lct_in_if.sink    i_link,
    lct_out_if.source o_contact
);
    import lct_pkg::*;

    localparam int DQ = Q_W;  // divider cells per axis

    logic w_adv;

    // Front stage registers.
    logic                               r_v0, r_v1, r_v2;
    logic [2:0][MAG_W-1:0]              r0_d;
    logic                               r0_rod;
    logic [REST_W-1:0]                  r0_rest;
    logic [RST_W-1:0]                   r0_rst;
    logic [2:0][SUM_W-1:0]              r1_sq;
    t_side                              r1_sd;
    logic [SUM_W-1:0]                   r2_sum;

    logic [2:0][MAG_W-1:0]              n1_mag;
    logic [2:0]                         n1_neg;
    logic                               w_rod_in;

    // Square-root chain.
    logic [RAD_W-1:0]  w_rad  [0:SQ_STAGES];
    logic [ROOT_W-1:0] w_root [0:SQ_STAGES];
    logic [SREM_W-1:0] w_srem [0:SQ_STAGES];
    t_side             r_ssd  [0:SQ_STAGES];
    logic              r_sv   [1:SQ_STAGES];

    // Post stage.
    t_post             n_post;
    logic [MAG_W-1:0]  w_len, w_rest33, w_diff, w_pen33;
    logic              w_lt;

    // Divider chain.
    logic [DREM_W-1:0] r_drem0 [0:2];
    logic [DREM_W-1:0] w_drem [0:2][0:DQ];
    logic [Q_W-1:0]    w_q    [0:2][0:DQ];
    t_post             r_dsb  [0:DQ];
    logic              r_dv   [0:DQ];

    // Output register.
    logic                        r_out_valid;
    logic [2:0][NRM_W-1:0]       r_nrm;
    logic [PEN_W-1:0]            r_pen;
    logic [RST_W-1:0]            r_rst;
    logic [2:0][NRM_W-1:0]       n_nrm;

    assign w_adv        = !r_out_valid || o_contact.ready;
    assign i_link.ready = w_adv;

    assign w_rod_in = (t_cmd'(i_link.cmd) == CMD_PAIR_ROD) ||
                      (t_cmd'(i_link.cmd) == CMD_ANCH_ROD);

    // Valid bits of every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            for (int k = 1; k <= SQ_STAGES; k++) r_sv[k] <= 1'b0;
            for (int k = 0; k <= DQ; k++) r_dv[k] <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v0 <= i_link.valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_sv[1] <= r_v2;
            for (int k = 2; k <= SQ_STAGES; k++) r_sv[k] <= r_sv[k-1];
            r_dv[0] <= r_sv[SQ_STAGES];
            for (int k = 1; k <= DQ; k++) r_dv[k] <= r_dv[k-1];
            // Links without a contact are dropped here.
            r_out_valid <= r_dv[DQ] && r_dsb[DQ].emit;
        end
    end

    // Stage 0: differences from first to second point.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_d[0] <= {i_link.second_x[31], i_link.second_x} -
                       {i_link.first_x[31], i_link.first_x};
            r0_d[1] <= {i_link.second_y[31], i_link.second_y} -
                       {i_link.first_y[31], i_link.first_y};
            r0_d[2] <= {i_link.second_z[31], i_link.second_z} -
                       {i_link.first_z[31], i_link.first_z};
            r0_rod  <= w_rod_in;
            r0_rest <= i_link.rest_length;
            r0_rst  <= i_link.restitution;
        end
    end

    // Stage 1: magnitudes and their squares.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n1_neg[c] = r0_d[c][MAG_W-1];
            n1_mag[c] = n1_neg[c] ? (~r0_d[c] + MAG_W'(1)) : r0_d[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < 3; c++) begin
                r1_sq[c] <= n1_mag[c] * n1_mag[c];
            end
            r1_sd.mag  <= n1_mag;
            r1_sd.neg  <= n1_neg;
            r1_sd.rod  <= r0_rod;
            r1_sd.rest <= r0_rest;
            r1_sd.rst  <= r0_rst;
        end
    end

    // Stage 2: squared length.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_sum     <= r1_sq[0] + r1_sq[1] + r1_sq[2];
            r_ssd[0]   <= r1_sd;
        end
    end

    // Square-root chain over the squared length scaled by 2^32.
    assign w_rad[0]  = {r2_sum, 32'd0};
    assign w_root[0] = '0;
    assign w_srem[0] = '0;

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
        lct_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_rad  (w_rad[k]),
            .i_root (w_root[k]),
            .i_rem  (w_srem[k]),
            .o_rad  (w_rad[k+1]),
            .o_root (w_root[k+1]),
            .o_rem  (w_srem[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_ssd[k+1] <= r_ssd[k];
            end
        end
    end

    // Post stage: length, emit decision, penetration with saturation.
    always_comb begin
        w_len    = w_root[SQ_STAGES][ROOT_W-1:16];
        w_rest33 = {2'b00, r_ssd[SQ_STAGES].rest};
        w_lt     = (w_len < w_rest33);
        w_diff   = w_len - w_rest33;
        w_pen33  = (r_ssd[SQ_STAGES].rod && w_lt) ? (w_rest33 - w_len) : w_diff;
        n_post.den  = w_root[SQ_STAGES];
        n_post.emit = r_ssd[SQ_STAGES].rod ? (w_len != w_rest33) : !w_lt;
        n_post.flip = r_ssd[SQ_STAGES].rod && w_lt;
        n_post.pen  = w_pen33[MAG_W-1] ? '1 : w_pen33[PEN_W-1:0];
        n_post.rst  = r_ssd[SQ_STAGES].rod ? '0 : r_ssd[SQ_STAGES].rst;
        n_post.neg  = r_ssd[SQ_STAGES].neg;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dsb[0] <= n_post;
            for (int c = 0; c < 3; c++) begin
                r_drem0[c] <= DREM_W'({r_ssd[SQ_STAGES].mag[c], 15'd0});
            end
        end
    end

    // Divider chain: each normal component is |d| * 2^30 / length.
    for (genvar c = 0; c < 3; c++) begin : g_axis
        assign w_q[c][0]    = '0;
        assign w_drem[c][0] = r_drem0[c];
        for (genvar k = 0; k < DQ; k++) begin : g_div
            lct_div_cell u_cell (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_den (r_dsb[k].den),
                .i_rem (w_drem[c][k]),
                .i_q   (w_q[c][k]),
                .o_rem (w_drem[c][k+1]),
                .o_q   (w_q[c][k+1])
            );
        end
    end

    for (genvar k = 0; k < DQ; k++) begin : g_dsb
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dsb[k+1] <= r_dsb[k];
            end
        end
    end

    // Output stage: apply sign; a zero-length link gives a zero normal.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_dsb[DQ].den == '0) begin
                n_nrm[c] = '0;
            end else if (r_dsb[DQ].neg[c] ^ r_dsb[DQ].flip) begin
                n_nrm[c] = NRM_W'(0) - {1'b0, w_q[c][DQ]};
            end else begin
                n_nrm[c] = {1'b0, w_q[c][DQ]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_nrm <= n_nrm;
            r_pen <= r_dsb[DQ].pen;
            r_rst <= r_dsb[DQ].rst;
        end
    end

    assign o_contact.valid           = r_out_valid;
    assign o_contact.normal_x        = r_nrm[0];
    assign o_contact.normal_y        = r_nrm[1];
    assign o_contact.normal_z        = r_nrm[2];
    assign o_contact.penetration     = r_pen;
    assign o_contact.restitution_out = r_rst;
endmodule
`default_nettype wire

/* rtl/lct_sqrt_cell.sv */
// One cell of the square-root chain: resolves one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module lct_sqrt_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [lct_pkg::RAD_W-1:0]  i_rad,
    input  wire logic [lct_pkg::ROOT_W-1:0] i_root,
    input  wire logic [lct_pkg::SREM_W-1:0] i_rem,
    output logic      [lct_pkg::RAD_W-1:0]  o_rad,
    output logic      [lct_pkg::ROOT_W-1:0] o_root,
    output logic      [lct_pkg::SREM_W-1:0] o_rem
);
    import lct_pkg::*;

    logic [SREM_W-1:0] w_sh;
    logic [SREM_W-1:0] w_trial;
    logic              w_ge;
    logic [RAD_W-1:0]  n_rad;
    logic [ROOT_W-1:0] n_root;
    logic [SREM_W-1:0] n_rem;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_root;
    logic [SREM_W-1:0] r_rem;

    // The remainder never exceeds twice the partial root, so its top two bits are free.
    always_comb begin
        w_sh    = {i_rem[SREM_W-3:0], i_rad[RAD_W-1 -: 2]};
        w_trial = {1'b0, i_root, 2'b01};
        w_ge    = (w_sh >= w_trial);
        n_rad   = {i_rad[RAD_W-3:0], 2'b00};
        n_root  = {i_root[ROOT_W-2:0], w_ge};
        n_rem   = w_ge ? (w_sh - w_trial) : w_sh;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_root <= n_root;
            r_rem  <= n_rem;
        end
    end

    assign o_rad  = r_rad;
    assign o_root = r_root;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

/* rtl/lct_div_cell.sv */
// One cell of the normal divider chain: resolves one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module lct_div_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [lct_pkg::ROOT_W-1:0] i_den,
    input  wire logic [lct_pkg::DREM_W-1:0] i_rem,
    input  wire logic [lct_pkg::Q_W-1:0]    i_q,
    output logic      [lct_pkg::DREM_W-1:0] o_rem,
    output logic      [lct_pkg::Q_W-1:0]    o_q
);
    import lct_pkg::*;

    logic [DREM_W-1:0] w_sh;
    logic              w_ge;
    logic [DREM_W-1:0] n_rem;
    logic [Q_W-1:0]    n_q;
    logic [DREM_W-1:0] r_rem;
    logic [Q_W-1:0]    r_q;

    // The remainder stays below the divisor, so the shift loses nothing.
    // Numerator bits brought down here are all zero.
    always_comb begin
        w_sh  = {i_rem[DREM_W-2:0], 1'b0};
        w_ge  = (w_sh >= {1'b0, i_den});
        n_rem = w_ge ? (w_sh - {1'b0, i_den}) : w_sh;
        n_q   = {i_q[Q_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_rem = r_rem;
    assign o_q   = r_q;
endmodule
`default_nettype wire

/* rtl/lct_checker.sv */
// Port-level checks for the link contact generator and their binding.
`timescale 1ns / 1ps
`default_nettype none
module lct_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_nx,
    input wire logic [31:0] i_ny,
    input wire logic [31:0] i_nz
);
    localparam logic signed [31:0] OneQ30 = 32'sd1073741824;

    // A contact waiting on a stalled receiver stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("contact dropped while stalled");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("contact valid after reset");

    // Input backpressure only comes from a stalled, full output.
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output stall");

    // Normal components stay within unit magnitude.
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ($signed(i_nx) <= OneQ30) && ($signed(i_nx) >= -OneQ30) &&
                        ($signed(i_ny) <= OneQ30) && ($signed(i_ny) >= -OneQ30) &&
                        ($signed(i_nz) <= OneQ30) && ($signed(i_nz) >= -OneQ30))
        else $error("normal component out of range");
endmodule

bind link_contact_generator lct_checker u_lct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_link.ready),
    .i_out_valid (o_contact.valid),
    .i_out_ready (o_contact.ready),
    .i_nx        (o_contact.normal_x),
    .i_ny        (o_contact.normal_y),
    .i_nz        (o_contact.normal_z)
);
`default_nettype wire
